>>> hdl/fba_pkg.sv
package fba_pkg;

  // Frame space and bitmap geometry.
  localparam int NUM_FRAMES   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int FRAME_W      = 12;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int NWORDS       = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int FIELD_FRAMES = 1 << FRAME_W;

  // Only frames that frame_out can name are ever handed out.
  localparam int SCAN_LIMIT   = (NUM_FRAMES < FIELD_FRAMES) ? NUM_FRAMES : FIELD_FRAMES;
  localparam int SCAN_WORDS   = (SCAN_LIMIT + WORD_BITS - 1) / WORD_BITS;

  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MAPPED = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

endpackage

>>> hdl/fba_req_if.sv
interface fba_req_if import fba_pkg::*; ();
  logic               valid;
  logic               ready;
  func_t              func;
  logic [FRAME_W-1:0] frame_number;
  logic               kernel_page;
  logic               rw_page;

  modport source (output valid, output func, output frame_number, output kernel_page,
                  output rw_page, input ready);
  modport sink   (input valid, input func, input frame_number, input kernel_page,
                  input rw_page, output ready);
endinterface

>>> hdl/fba_rsp_if.sv
interface fba_rsp_if import fba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_out;
  logic               present;
  logic               writable;
  logic               user_mode;
  status_t            status;

  modport source (output valid, output frame_out, output present, output writable,
                  output user_mode, output status, input ready);
  modport sink   (input valid, input frame_out, input present, input writable,
                  input user_mode, input status, output ready);
endinterface

>>> hdl/frame_bitmap_allocator.sv
// Channel  Dir  Fields
// req      in   func, frame_number, kernel_page, rw_page
// rsp      out  frame_out, present, writable, user_mode, status
//
// An allocate scans the bitmap RAM, which delivers one registered word per cycle,
// and the scan stops at the first word with a clear bit. A free reads its word
// and clears the bit; an already-mapped request goes straight to the done state.
// Synchronous reset clears one valid flag per bitmap word, so no clearing pass.
// The result sits in an output register; a new transaction is taken while it
// waits, and the next result waits in the done state until the register drains.
module frame_bitmap_allocator import fba_pkg::*; (
  input  logic clk,
  input  logic rst,
  fba_req_if.sink   req,
  fba_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FREE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // Captured request.
  logic               op_free;
  logic [FRAME_W-1:0] op_frame;
  logic               op_kernel;
  logic               op_writable;

  // Bitmap RAM, its per-word valid flags and the read pipeline.
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    valid_bits;
  logic [WADDR_W-1:0]   addr;
  logic [WADDR_W-1:0]   chk;
  logic [WORD_BITS-1:0] word_q;
  logic                 word_vld_q;

  // Pending result.
  logic [FRAME_W-1:0] res_frame;
  logic               res_present;
  logic               res_writable;
  logic               res_user;
  status_t            res_status;

  logic [WORD_BITS-1:0]     word;
  logic [BIT_W-1:0]         zero_idx;
  logic [WADDR_W+BIT_W-1:0] found;
  logic                     hit;
  logic                     last;
  logic                     free_in_range;
  logic                     we;
  logic [WORD_BITS-1:0]     wd;
  logic                     slot_free;

  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // A word never written reads as all frames free.
  assign word     = word_vld_q ? word_q : '0;
  assign zero_idx = lowest_zero(word);
  assign found    = {chk, zero_idx};
  assign hit      = (state == S_SCAN) && (word != FULL_WORD) &&
                    (32'(found) < 32'(SCAN_LIMIT));
  assign last     = (chk == WADDR_W'(SCAN_WORDS - 1));

  assign free_in_range = 32'(op_frame) < 32'(NUM_FRAMES);

  // Write back the word under test: clear a bit on free, set one on allocate.
  assign we = ((state == S_FREE) && free_in_range) || hit;
  assign wd = (state == S_FREE) ? (word & ~(WORD_BITS'(1) << op_frame[BIT_W-1:0]))
                                : (word | (WORD_BITS'(1) << zero_idx));

  assign slot_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // Bitmap storage with registered read.
  always_ff @(posedge clk) begin
    if (we) mem[chk] <= wd;
    word_q <= mem[addr];
  end

  // Valid flags, cleared all at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      word_vld_q <= 1'b0;
    end else begin
      if (we) valid_bits[chk] <= 1'b1;
      word_vld_q <= valid_bits[addr];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      addr      <= '0;
      chk       <= '0;
    end else begin
      // The output register fills from the done state and empties on a handshake.
      if ((state == S_DONE) && slot_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      chk <= addr;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_free     <= (req.func == FUNC_FREE);
            op_frame    <= req.frame_number;
            op_kernel   <= req.kernel_page;
            op_writable <= req.rw_page;
            if (req.func == FUNC_FREE) begin
              addr  <= WADDR_W'(req.frame_number >> BIT_W);
              state <= S_READ;
            end else if (req.frame_number != '0) begin
              res_frame    <= req.frame_number;
              res_present  <= 1'b0;
              res_writable <= 1'b0;
              res_user     <= 1'b0;
              res_status   <= ST_MAPPED;
              state        <= S_DONE;
            end else begin
              addr  <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // Wait for the first word; keep the scan address one ahead.
          if (!op_free) addr <= addr + 1'b1;
          state <= op_free ? S_FREE : S_SCAN;
        end
        S_FREE: begin
          res_frame    <= op_frame;
          res_present  <= 1'b0;
          res_writable <= 1'b0;
          res_user     <= 1'b0;
          res_status   <= ST_OK;
          state        <= S_DONE;
        end
        S_SCAN: begin
          addr <= addr + 1'b1;
          if (hit) begin
            res_frame    <= FRAME_W'(found);
            res_present  <= 1'b1;
            res_writable <= op_writable;
            res_user     <= !op_kernel;
            res_status   <= ST_OK;
            state        <= S_DONE;
          end else if (last) begin
            res_frame    <= '0;
            res_present  <= 1'b0;
            res_writable <= 1'b0;
            res_user     <= 1'b0;
            res_status   <= ST_FULL;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            rsp.frame_out <= res_frame;
            rsp.present   <= res_present;
            rsp.writable  <= res_writable;
            rsp.user_mode <= res_user;
            rsp.status    <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The bit chosen by the scan was really free.
  a_hit_bit_clear: assert property (@(posedge clk) disable iff (rst)
    hit |-> !word[zero_idx])
    else $error("scan picked a used frame");

  // A scan that misses moves on to the next word.
  a_scan_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && !hit && !last |=>
      (state == S_SCAN) && (chk == WADDR_W'($past(chk) + 1'b1)))
    else $error("scan skipped or repeated a word");

  // A finished result is loaded once the output register is free.
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && slot_free |=> rsp.valid && (state == S_IDLE))
    else $error("result not loaded");

  // Only a successful allocation sets the present bit.
  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.present |-> (rsp.status == ST_OK))
    else $error("present set on a failed request");

endmodule
